>>> rtl/core/crc_kpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_kpr_pkg
// Shared types, constants and the CRC-32 byte update for the key router.
// ----------------------------------------------------------------------------
package crc_kpr_pkg;

  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
  localparam int          DIV_STEPS  = 32;
  localparam int          CNT_W      = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [7:0] key_byte;
    logic       is_last;
    logic       is_empty;
  } key_item_t;

  typedef struct packed {
    logic [15:0] part_id;
    logic [31:0] key_hash;
  } result_item_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DIVIDE
  } ctrl_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic crc_update;   // fold a middle byte into the running CRC
    logic crc_final;    // fold the last byte, load the divider, restart the CRC
    logic crc_restart;  // drop a partial key
    logic put_empty;    // load the result register with the empty-key result
    logic div_step;     // one restoring division step
    logic put_div;      // load the result register with hash and remainder
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic result_full;
    logic div_last;
  } dp_status_t;

  // Reflected CRC-32, one byte, eight bit steps
  function automatic logic [31:0] crc_byte_update(input logic [31:0] crc,
                                                  input logic [7:0]  data);
    logic [31:0] c;
    c = crc ^ {24'h0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/core/crc_kpr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_kpr_ctrl
// Controller: input handshake and sequencing of CRC and modulo steps.
// ----------------------------------------------------------------------------
module crc_kpr_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    key_valid,
  input  logic                    is_last,
  input  logic                    is_empty,
  input  logic                    result_stall,
  input  crc_kpr_pkg::dp_status_t status,
  output logic                    key_stall,
  output crc_kpr_pkg::dp_cmd_t    cmd
);
  import crc_kpr_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    key_stall  = 1'b1;
    accept     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // hold input while a result waits and is not being taken
        key_stall = status.result_full && result_stall;
        accept    = key_valid && !key_stall;
        if (accept) begin
          if (is_empty) begin
            cmd.crc_restart = 1'b1;
            cmd.put_empty   = 1'b1;
          end else if (is_last) begin
            cmd.crc_final = 1'b1;
            state_next    = ST_DIVIDE;
          end else begin
            cmd.crc_update = 1'b1;
          end
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          cmd.put_div = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/crc_kpr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_kpr_datapath
// Running CRC, partition count register, bit-serial divider, result register.
// ----------------------------------------------------------------------------
module crc_kpr_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [7:0]                key_byte,
  input  logic                      cfg_valid,
  input  logic [15:0]               cfg_data,
  input  crc_kpr_pkg::dp_cmd_t      cmd,
  input  logic                      result_stall,
  output crc_kpr_pkg::dp_status_t   status,
  output logic                      result_valid,
  output crc_kpr_pkg::result_item_t result_item
);
  import crc_kpr_pkg::*;

  logic [31:0]      running_crc;
  logic [15:0]      part_total;
  logic [31:0]      hash;
  logic [31:0]      dividend;
  logic [15:0]      remainder;
  logic [CNT_W-1:0] step_count;

  logic [31:0] crc_next;
  logic [16:0] shifted;
  logic [16:0] diff;
  logic [15:0] remainder_next;

  assign crc_next = crc_byte_update(running_crc, key_byte);

  // restoring step: remainder stays below the divisor, so 16 bits suffice
  assign shifted        = {remainder, dividend[31]};
  assign diff           = shifted - {1'b0, part_total};
  assign remainder_next = diff[16] ? shifted[15:0] : diff[15:0];

  assign status.div_last    = (step_count == CNT_W'(DIV_STEPS - 1));
  assign status.result_full = result_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc  <= CRC_PRESET;
      part_total   <= 16'd1;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        part_total <= cfg_data;
      end
      if (cmd.crc_update) begin
        running_crc <= crc_next;
      end else if (cmd.crc_final || cmd.crc_restart) begin
        running_crc <= CRC_PRESET;
      end
      if (cmd.put_empty || cmd.put_div) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.crc_final) begin
      hash       <= ~crc_next;
      dividend   <= ~crc_next;
      remainder  <= '0;
      step_count <= '0;
    end else if (cmd.div_step) begin
      dividend   <= {dividend[30:0], 1'b0};
      remainder  <= remainder_next;
      step_count <= step_count + 1'b1;
    end
    if (cmd.put_empty) begin
      result_item <= '0;
    end else if (cmd.put_div) begin
      result_item.key_hash <= hash;
      result_item.part_id  <= (part_total == 16'd0) ? 16'd0 : remainder_next;
    end
  end

endmodule

>>> rtl/core/crc32_key_partition_router_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32_key_partition_router_unit
// Hashes key bytes with CRC-32 and picks a partition as CRC mod count.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   key       in         key_valid / key_stall   key_item_t    (byte, last, empty)
//   result    out        result_valid / _stall   result_item_t (partition, hash)
//   cfg       in         cfg_valid / cfg_ready   partition count, 16 bits
//
// Bytes of one key stream back to back unless the result register is full
// and result_stall is high. A last byte is folded in, then 32 steps of the
// bit-serial restoring divider form CRC mod the partition count. Reset
// (rst, synchronous) presets the CRC to all ones, sets the partition count
// to 1 and empties the result register.
// Input stalls while the result register is full and result_stall is high,
// and for the whole division.
//
module crc32_key_partition_router_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      key_valid,
  output logic                      key_stall,
  input  crc_kpr_pkg::key_item_t    key_item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output crc_kpr_pkg::result_item_t result_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [15:0]               cfg_data
);
  import crc_kpr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // register writes are never held off
  assign cfg_ready = 1'b1;

  crc_kpr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .key_valid    (key_valid),
    .is_last      (key_item.is_last),
    .is_empty     (key_item.is_empty),
    .result_stall (result_stall),
    .status       (status),
    .key_stall    (key_stall),
    .cmd          (cmd)
  );

  crc_kpr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .key_byte     (key_item.key_byte),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .result_stall (result_stall),
    .status       (status),
    .result_valid (result_valid),
    .result_item  (result_item)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CRC-32 key partition router: a short table of
// known keys and register settings, then random keys over several partition
// counts, with every result checked in order against a typed answer or a local CRC/modulo model.
// ----------------------------------------------------------------------------
module tb_top;
  import crc_kpr_pkg::*;

  // Quiet margin after the last result drains, before touching config.
  localparam int SETTLE_CYCLES = 40;
  // Result-side hold-off used once to back the block up into its input.
  localparam int LONG_HOLD     = 300;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 72;

  // One row of the directed table: either a register write or a key item,
  // optionally with the result typed in by hand.
  typedef struct packed {
    logic         is_cfg;
    logic [15:0]  cfg_value;
    key_item_t    item;
    logic         checked;
    result_item_t want;
  } plan_row_t;

  localparam int PLAN_ROWS = 25;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // partition count 1 out of reset
    '{1'b0, 16'd0, '{8'h00, 1'b0, 1'b1}, 1'b1, '{16'd0, 32'h0000_0000}},
    '{1'b0, 16'd0, '{8'hFF, 1'b1, 1'b1}, 1'b1, '{16'd0, 32'h0000_0000}},
    '{1'b0, 16'd0, '{8'h00, 1'b1, 1'b0}, 1'b1, '{16'd0, 32'hD202_EF8D}},
    '{1'b0, 16'd0, '{8'hFF, 1'b1, 1'b0}, 1'b1, '{16'd0, 32'hFF00_0000}},
    // the usual check string "123456789"
    '{1'b0, 16'd0, '{8'h31, 1'b0, 1'b0}, 1'b0, '{16'd0, 32'h0}},
    '{1'b0, 16'd0, '{8'h32, 1'b0, 1'b0}, 1'b0, '{16'd0, 32'h0}},
    '{1'b0, 16'd0, '{8'h33, 1'b0, 1'b0}, 1'b0, '{16'd0, 32'h0}},
    '{1'b0, 16'd0, '{8'h34, 1'b0, 1'b0}, 1'b0, '{16'd0, 32'h0}},
    '{1'b0, 16'd0, '{8'h35, 1'b0, 1'b0}, 1'b0, '{16'd0, 32'h0}},
    '{1'b0, 16'd0, '{8'h36, 1'b0, 1'b0}, 1'b0, '{16'd0, 32'h0}},
    '{1'b0, 16'd0, '{8'h37, 1'b0, 1'b0}, 1'b0, '{16'd0, 32'h0}},
    '{1'b0, 16'd0, '{8'h38, 1'b0, 1'b0}, 1'b0, '{16'd0, 32'h0}},
    '{1'b0, 16'd0, '{8'h39, 1'b1, 1'b0}, 1'b1, '{16'd0, 32'hCBF4_3926}},
    // empty key in the middle of a partial key drops the partial bytes
    '{1'b0, 16'd0, '{8'h61, 1'b0, 1'b0}, 1'b0, '{16'd0, 32'h0}},
    '{1'b0, 16'd0, '{8'h62, 1'b0, 1'b0}, 1'b0, '{16'd0, 32'h0}},
    '{1'b0, 16'd0, '{8'hA5, 1'b0, 1'b1}, 1'b1, '{16'd0, 32'h0000_0000}},
    '{1'b0, 16'd0, '{8'hFF, 1'b1, 1'b0}, 1'b1, '{16'd0, 32'hFF00_0000}},
    // zero partition count: index 0, hash still valid
    '{1'b1, 16'd0, '{8'h00, 1'b0, 1'b0}, 1'b0, '{16'd0, 32'h0}},
    '{1'b0, 16'd0, '{8'h00, 1'b1, 1'b0}, 1'b1, '{16'd0, 32'hD202_EF8D}},
    // largest partition count
    '{1'b1, 16'hFFFF, '{8'h00, 1'b0, 1'b0}, 1'b0, '{16'd0, 32'h0}},
    '{1'b0, 16'd0, '{8'hFF, 1'b1, 1'b0}, 1'b0, '{16'd0, 32'h0}},
    // two partitions: odd hash lands in partition 1
    '{1'b1, 16'd2, '{8'h00, 1'b0, 1'b0}, 1'b0, '{16'd0, 32'h0}},
    '{1'b0, 16'd0, '{8'h00, 1'b1, 1'b0}, 1'b1, '{16'd1, 32'hD202_EF8D}},
    '{1'b0, 16'd0, '{8'h80, 1'b0, 1'b0}, 1'b0, '{16'd0, 32'h0}},
    '{1'b0, 16'd0, '{8'h7F, 1'b1, 1'b0}, 1'b0, '{16'd0, 32'h0}}
  };

  logic         clk;
  logic         rst;
  logic         key_valid;
  logic         key_stall;
  key_item_t    key_item;
  logic         result_valid;
  logic         result_stall;
  result_item_t result_item;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [15:0]  cfg_data;

  // Local copy of the block state and its one register
  logic [31:0]  crc_acc;
  logic [15:0]  part_count;

  result_item_t pending_routes [$];
  result_item_t head_route;
  int           mismatches;
  logic         hold_request;
  logic         no_idle;

  crc32_key_partition_router_unit dut (
    .clk          (clk),
    .rst          (rst),
    .key_valid    (key_valid),
    .key_stall    (key_stall),
    .key_item     (key_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Fold one item into the local CRC; report whether it closes a key and
  // what the block should return for it.
  function automatic void route_key_item(input key_item_t it, output logic gives,
                                         output result_item_t res);
    logic [31:0] folded;
    logic [31:0] hash;
    gives = 1'b0;
    res   = '0;
    if (it.is_empty) begin
      // drop any partial key, answer partition 0 / hash 0
      crc_acc = CRC_PRESET;
      gives   = 1'b1;
    end else begin
      folded = crc_acc ^ {24'h0, it.key_byte};
      for (int k = 0; k < 8; k++) begin
        folded = folded[0] ? ((folded >> 1) ^ CRC_POLY) : (folded >> 1);
      end
      crc_acc = folded;
      if (it.is_last) begin
        hash    = folded ^ 32'hFFFF_FFFF;
        crc_acc = CRC_PRESET;
        gives   = 1'b1;
        res.key_hash = hash;
        res.part_id  = (part_count != 16'd0) ? 16'(hash % part_count) : 16'd0;
      end
    end
  endfunction

  // Drive one item, hold it until accepted, then log what it should produce.
  task automatic offer_key(input key_item_t it, input logic typed,
                           input result_item_t typed_res);
    logic         gives;
    result_item_t res;
    @(negedge clk);
    key_valid <= 1'b1;
    key_item  <= it;
    @(posedge clk);
    while (key_stall) @(posedge clk);
    route_key_item(it, gives, res);
    if (gives) begin
      pending_routes.push_back(typed ? typed_res : res);
    end
  endtask

  // Drop valid; n sets the length of the gap (nothing if n is 0).
  task automatic idle_keys(input int n);
    if (n > 0) begin
      @(negedge clk);
      key_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Let the block drain and settle, then write the partition count.
  task automatic set_partition_count(input logic [15:0] value);
    idle_keys(1);
    while (pending_routes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    part_count = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly back to back, sometimes a few cycles, rarely a long gap.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: open and stalled runs of random length, plus one long
  // hold-off on request so the block backs up and stalls its input.
  initial begin
    int open_len;
    int stall_len;
    int hold_n;
    result_stall = 1'b0;
    forever begin
      if (hold_request) begin
        @(negedge clk);
        result_stall <= 1'b1;
        for (hold_n = 0; hold_n < LONG_HOLD; hold_n++) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        open_len  = $urandom_range(1, 12);
        stall_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                 : $urandom_range(10, 50);
        @(negedge clk);
        result_stall <= 1'b0;
        repeat (open_len - 1) @(negedge clk);
        if (!no_idle) begin
          @(negedge clk);
          result_stall <= 1'b1;
          repeat (stall_len - 1) @(negedge clk);
        end
      end
    end
  end

  // Check every accepted result against the oldest outstanding expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_routes.size() == 0) begin
        $display("%0t: unexpected result, expected none, got part %0d hash %08h",
                 $time, result_item.part_id, result_item.key_hash);
        mismatches++;
      end else begin
        head_route = pending_routes.pop_front();
        if (result_item.part_id !== head_route.part_id) begin
          $display("%0t: part_id expected %0d got %0d", $time,
                   head_route.part_id, result_item.part_id);
          mismatches++;
        end
        if (result_item.key_hash !== head_route.key_hash) begin
          $display("%0t: key_hash expected %08h got %08h", $time,
                   head_route.key_hash, result_item.key_hash);
          mismatches++;
        end
      end
    end
  end

  // Stimulus: directed table, then random keys over several partition counts.
  initial begin
    key_item_t   it;
    logic [15:0] count;
    int          sent;
    int          len;
    int          b;
    logic        broken;
    logic        paused;

    rst          = 1'b1;
    key_valid    = 1'b0;
    key_item     = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    hold_request = 1'b0;
    no_idle      = 1'b0;
    mismatches   = 0;
    crc_acc      = CRC_PRESET;
    part_count   = 16'd1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the table; typed rows carry their answer, the rest use the model.
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].is_cfg) begin
        set_partition_count(PLAN[i].cfg_value);
      end else begin
        offer_key(PLAN[i].item, PLAN[i].checked, PLAN[i].want);
        idle_keys(draw_gap());
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       count = 16'hFFFF;
        1:       count = 16'($urandom_range(1, 65535));
        2:       count = 16'd0;
        3:       count = 16'd1;
        4:       count = 16'd2;
        5:       count = 16'($urandom_range(3, 16));
        default: count = 16'($urandom_range(0, 65535));
      endcase
      set_partition_count(count);
      // phase 3 runs with no idling on either side
      no_idle = (ph == 3);
      // phase 1 opens with the long result-side hold-off
      if (ph == 1) hold_request = 1'b1;
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        // halfway through, hold the input until every result is back
        if (!paused && sent >= PHASE_ITEMS / 2) begin
          idle_keys(1);
          while (pending_routes.size() != 0) @(posedge clk);
          paused = 1'b1;
        end
        if ($urandom_range(0, 99) < 6) begin
          // lone empty-key item with junk in the ignored fields
          it.key_byte = 8'($urandom_range(0, 255));
          it.is_last  = 1'($urandom_range(0, 1));
          it.is_empty = 1'b1;
          offer_key(it, 1'b0, '0);
          idle_keys(draw_gap());
          sent++;
        end else begin
          len    = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                               : $urandom_range(1, 6);
          broken = ($urandom_range(0, 9) == 0);
          for (b = 0; b < len; b++) begin
            it.key_byte = 8'($urandom_range(0, 255));
            it.is_last  = (b == len - 1) && !broken;
            it.is_empty = 1'b0;
            offer_key(it, 1'b0, '0);
            idle_keys(draw_gap());
            sent++;
          end
          if (broken) begin
            // abort the partial key with an empty-key item
            it.key_byte = 8'($urandom_range(0, 255));
            it.is_last  = 1'($urandom_range(0, 1));
            it.is_empty = 1'b1;
            offer_key(it, 1'b0, '0);
            idle_keys(draw_gap());
            sent++;
          end
        end
      end
    end

    // Drain, let any trailing division finish, then report.
    no_idle = 1'b0;
    idle_keys(1);
    while (pending_routes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_routes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop if the block hangs.
  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

endmodule
